### rtl/core/segment_free_list_allocator_macros.svh
// assertion macros for the segment free list allocator
// used by the top level; expects aclk and aresetn in scope
`ifndef SEGMENT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define SEGMENT_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SFLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sfla_pkg.sv
// shared types, codes and defaults for the segment free list allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

    localparam int MEM_WORDS_DEF  = 65536;
    localparam int FREE_SLOTS_DEF = 32;
    localparam int ID_COUNT_DEF   = 64;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int ID_W   = 6;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_INUSE   = 3'd3,
        ST_BADSIZE = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_OPEN  = 2'd1,
        SH_CLOSE = 2'd2
    } shift_t;

    typedef enum logic [3:0] {
        S_IDLE     = 4'd0,
        S_DECODE   = 4'd1,
        S_ALLOC    = 4'd2,
        S_SCAN_RD  = 4'd3,
        S_SCAN_CHK = 4'd4,
        S_SHIFT_RD = 4'd5,
        S_SHIFT_WR = 4'd6,
        S_WRITE_A  = 4'd7,
        S_WRITE_B  = 4'd8,
        S_FINISH   = 4'd9
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } free_entry_t;

endpackage

`default_nettype wire

### rtl/core/sfla_free_table.sv
// free segment table: one write port, one registered read port
// uses sfla_pkg; entry 0 reads as the whole memory until first written
`timescale 1ns / 1ps
`default_nettype none

module sfla_free_table #(
    parameter int FREE_SLOTS = sfla_pkg::FREE_SLOTS_DEF,
    parameter int MEM_WORDS  = sfla_pkg::MEM_WORDS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 rd_en,
    input  wire [$clog2(FREE_SLOTS)-1:0]        rd_addr,
    output sfla_pkg::free_entry_t               rd_data,
    input  wire                                 wr_en,
    input  wire [$clog2(FREE_SLOTS)-1:0]        wr_addr,
    input  wire sfla_pkg::free_entry_t          wr_data
);

    localparam int TW = $clog2(FREE_SLOTS);

    sfla_pkg::free_entry_t mem [FREE_SLOTS];
    sfla_pkg::free_entry_t rd_q_reg;
    logic                  rd_zero_reg;
    logic                  seeded_reg;
    logic                  rd_seeded_reg;
    sfla_pkg::free_entry_t seed_entry;

    assign seed_entry.start = '0;
    assign seed_entry.len   = sfla_pkg::LEN_W'(MEM_WORDS);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg      <= mem[rd_addr];
            rd_zero_reg   <= (rd_addr == TW'(0));
            rd_seeded_reg <= seeded_reg;
        end
    end

    // entry 0 holds the reset segment until the first write there
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg <= 1'b0;
        end else if (wr_en && wr_addr == TW'(0)) begin
            seeded_reg <= 1'b1;
        end
    end

    assign rd_data = (rd_zero_reg && !rd_seeded_reg) ? seed_entry : rd_q_reg;

endmodule

`default_nettype wire

### rtl/core/segment_free_list_allocator.sv
// top level of the segment free list allocator: sequencer, id table, output stage
// uses sfla_pkg, sfla_free_table and segment_free_list_allocator_macros.svh
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  width  contents
// s_axis    in   48     command, seg_id, start_addr, length
// m_axis    out  24     status, position
//
// one transaction at a time; s_tready is high only while idle
// scan reads and then checks each table entry; each moved entry is read and then written
// the worst-case run time is set by the single table port
// a finished result waits in the output register while the next command is taken
// synchronous active-low reset; no clearing pass (fill count plus seeded entry 0)

`include "segment_free_list_allocator_macros.svh"

module segment_free_list_allocator #(
    parameter int MEM_WORDS  = sfla_pkg::MEM_WORDS_DEF,
    parameter int FREE_SLOTS = sfla_pkg::FREE_SLOTS_DEF,
    parameter int ID_COUNT   = sfla_pkg::ID_COUNT_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // command[1:0], seg_id[7:2], start_addr[23:8], length[40:24]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // status[2:0], position[18:3]
);

    localparam int TW       = $clog2(FREE_SLOTS);
    localparam int CW       = $clog2(FREE_SLOTS + 2);
    localparam int ID_DEPTH = (ID_COUNT < 64) ? ID_COUNT : 64;
    localparam int IW       = $clog2(ID_DEPTH);
    localparam int AW       = sfla_pkg::ADDR_W;
    localparam int LW       = sfla_pkg::LEN_W;

    // sequencer and command latch
    sfla_pkg::state_t  state_reg, state_next;
    sfla_pkg::cmd_t    cmd_reg, cmd_next;
    logic [sfla_pkg::ID_W-1:0] id_reg, id_next;
    logic [AW-1:0]     st_reg, st_next;
    logic [LW-1:0]     sz_reg, sz_next;

    // scan position and previous entry seen by remove
    logic [CW-1:0]     k_reg, k_next;
    sfla_pkg::free_entry_t prev_reg, prev_next;
    logic              have_prev_reg, have_prev_next;

    // pending table edits
    sfla_pkg::shift_t  shift_reg, shift_next;
    logic [CW-1:0]     at_reg, at_next;
    logic [CW-1:0]     i_reg, i_next;
    logic              wb_en_reg, wb_en_next;
    logic [TW-1:0]     wa_addr_reg, wa_addr_next, wb_addr_reg, wb_addr_next;
    sfla_pkg::free_entry_t wa_data_reg, wa_data_next, wb_data_reg, wb_data_next;

    logic [CW-1:0]     count_reg, count_next;
    sfla_pkg::status_t status_reg, status_next;
    logic [AW-1:0]     pos_reg, pos_next;

    // output register
    logic              m_valid_reg;
    sfla_pkg::status_t m_status_reg;
    logic [AW-1:0]     m_pos_reg;

    // id bookkeeping
    logic                  alloc_valid_reg [ID_DEPTH];
    sfla_pkg::free_entry_t alloc_mem [ID_DEPTH];
    sfla_pkg::free_entry_t alloc_rd_reg;
    logic [IW-1:0]         id_idx;
    logic                  id_ok;
    logic                  out_free;
    logic                  finish_go;

    // free table port
    logic                  tbl_rd_en;
    logic [TW-1:0]         tbl_rd_addr;
    sfla_pkg::free_entry_t tbl_rd_data;
    logic                  tbl_wr_en;
    logic [TW-1:0]         tbl_wr_addr;
    sfla_pkg::free_entry_t tbl_wr_data;

    sfla_free_table #(
        .FREE_SLOTS (FREE_SLOTS),
        .MEM_WORDS  (MEM_WORDS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data)
    );

    assign id_idx    = id_reg[IW-1:0];
    assign id_ok     = (11'(id_reg) < 11'(ID_COUNT));
    assign out_free  = !m_valid_reg || m_tready;
    assign finish_go = (state_reg == sfla_pkg::S_FINISH) && out_free;

    // shared compare and add unit for the scanned entry
    logic [AW+1:0] end_w, ent_end, prev_end;
    logic          create_hit, query_hit, rem_stop, scan_done;
    logic          join_next, join_prev, tbl_full;

    assign end_w      = (AW+2)'(st_reg) + (AW+2)'(sz_reg);
    assign ent_end    = (AW+2)'(tbl_rd_data.start) + (AW+2)'(tbl_rd_data.len);
    assign prev_end   = (AW+2)'(prev_reg.start) + (AW+2)'(prev_reg.len);
    assign create_hit = (tbl_rd_data.start <= st_reg) && (ent_end >= end_w);
    assign query_hit  = (tbl_rd_data.len >= sz_reg);
    assign rem_stop   = (tbl_rd_data.start >= st_reg);
    assign scan_done  = (k_reg >= count_reg);
    assign join_next  = (state_reg == sfla_pkg::S_SCAN_CHK) &&
                        (end_w == (AW+2)'(tbl_rd_data.start));
    assign join_prev  = have_prev_reg && (prev_end == (AW+2)'(st_reg));
    assign tbl_full   = (count_reg >= CW'(FREE_SLOTS));

    // edit plan for the entry where create hits or remove stops, or for remove reaching the end
    logic                  plan_full;
    sfla_pkg::shift_t      plan_shift;
    logic [CW-1:0]         plan_at;
    logic                  plan_wb_en;
    logic [TW-1:0]         plan_wa_addr, plan_wb_addr;
    sfla_pkg::free_entry_t plan_wa_data, plan_wb_data;
    logic [CW-1:0]         k_prev, k_succ;

    assign k_prev = k_reg - CW'(1);
    assign k_succ = k_reg + CW'(1);

    always_comb begin
        plan_full          = 1'b0;
        plan_shift         = sfla_pkg::SH_NONE;
        plan_at            = k_reg;
        plan_wb_en         = 1'b0;
        plan_wa_addr       = k_reg[TW-1:0];
        plan_wb_addr       = k_reg[TW-1:0];
        plan_wa_data.start = tbl_rd_data.start;
        plan_wa_data.len   = LW'(st_reg - tbl_rd_data.start);
        plan_wb_data       = plan_wa_data;
        if (cmd_reg == sfla_pkg::CMD_CREATE) begin
            if (tbl_rd_data.start == st_reg) begin
                if (ent_end == end_w) begin
                    plan_shift = sfla_pkg::SH_CLOSE;
                end else begin
                    plan_wa_data.start = end_w[AW-1:0];
                    plan_wa_data.len   = LW'(ent_end - end_w);
                end
            end else if (end_w < ent_end) begin
                // split: tail goes in a new slot after the hit
                plan_full          = tbl_full;
                plan_shift         = sfla_pkg::SH_OPEN;
                plan_at            = k_succ;
                plan_wa_addr       = k_succ[TW-1:0];
                plan_wa_data.start = end_w[AW-1:0];
                plan_wa_data.len   = LW'(ent_end - end_w);
                plan_wb_en         = 1'b1;
            end
        end else begin
            if (join_prev && join_next) begin
                plan_shift         = sfla_pkg::SH_CLOSE;
                plan_wa_addr       = k_prev[TW-1:0];
                plan_wa_data.start = prev_reg.start;
                plan_wa_data.len   = prev_reg.len + sz_reg + tbl_rd_data.len;
            end else if (join_prev) begin
                plan_wa_addr       = k_prev[TW-1:0];
                plan_wa_data.start = prev_reg.start;
                plan_wa_data.len   = prev_reg.len + sz_reg;
            end else if (join_next) begin
                plan_wa_data.start = st_reg;
                plan_wa_data.len   = tbl_rd_data.len + sz_reg;
            end else begin
                plan_full          = tbl_full;
                plan_shift         = sfla_pkg::SH_OPEN;
                plan_wa_data.start = st_reg;
                plan_wa_data.len   = sz_reg;
            end
        end
    end

    // plan is taken at create hit, remove stop, or remove reaching the end
    logic plan_take;
    logic shift_more;

    always_comb begin
        plan_take = 1'b0;
        case (state_reg)
            sfla_pkg::S_SCAN_RD: begin
                plan_take = scan_done && (cmd_reg == sfla_pkg::CMD_REMOVE);
            end
            sfla_pkg::S_SCAN_CHK: begin
                plan_take = ((cmd_reg == sfla_pkg::CMD_CREATE) && create_hit) ||
                            ((cmd_reg == sfla_pkg::CMD_REMOVE) && rem_stop);
            end
            default: plan_take = 1'b0;
        endcase
    end

    assign shift_more = (shift_reg == sfla_pkg::SH_CLOSE) ? ((i_reg + CW'(1)) < count_reg)
                                                          : (i_reg > at_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfla_pkg::S_IDLE: begin
                if (s_tvalid) state_next = sfla_pkg::S_DECODE;
            end
            sfla_pkg::S_DECODE: begin
                case (cmd_reg)
                    sfla_pkg::CMD_CREATE: begin
                        if (!id_ok || alloc_valid_reg[id_idx] || sz_reg == '0) begin
                            state_next = sfla_pkg::S_FINISH;
                        end else begin
                            state_next = sfla_pkg::S_SCAN_RD;
                        end
                    end
                    sfla_pkg::CMD_REMOVE: begin
                        if (!id_ok || !alloc_valid_reg[id_idx]) begin
                            state_next = sfla_pkg::S_FINISH;
                        end else begin
                            state_next = sfla_pkg::S_ALLOC;
                        end
                    end
                    sfla_pkg::CMD_QUERY: begin
                        state_next = (sz_reg == '0) ? sfla_pkg::S_FINISH : sfla_pkg::S_SCAN_RD;
                    end
                    default: state_next = sfla_pkg::S_FINISH;
                endcase
            end
            sfla_pkg::S_ALLOC: state_next = sfla_pkg::S_SCAN_RD;
            sfla_pkg::S_SCAN_RD, sfla_pkg::S_SCAN_CHK: begin
                if (plan_take) begin
                    if (plan_full) begin
                        state_next = sfla_pkg::S_FINISH;
                    end else if (plan_shift != sfla_pkg::SH_NONE) begin
                        state_next = sfla_pkg::S_SHIFT_RD;
                    end else begin
                        state_next = sfla_pkg::S_WRITE_A;
                    end
                end else if (state_reg == sfla_pkg::S_SCAN_RD) begin
                    state_next = scan_done ? sfla_pkg::S_FINISH : sfla_pkg::S_SCAN_CHK;
                end else if (cmd_reg == sfla_pkg::CMD_QUERY && query_hit) begin
                    state_next = sfla_pkg::S_FINISH;
                end else begin
                    state_next = sfla_pkg::S_SCAN_RD;
                end
            end
            sfla_pkg::S_SHIFT_RD: begin
                if (shift_more) begin
                    state_next = sfla_pkg::S_SHIFT_WR;
                end else if (cmd_reg == sfla_pkg::CMD_CREATE &&
                             shift_reg == sfla_pkg::SH_CLOSE) begin
                    state_next = sfla_pkg::S_FINISH;
                end else begin
                    state_next = sfla_pkg::S_WRITE_A;
                end
            end
            sfla_pkg::S_SHIFT_WR: state_next = sfla_pkg::S_SHIFT_RD;
            sfla_pkg::S_WRITE_A: begin
                state_next = wb_en_reg ? sfla_pkg::S_WRITE_B : sfla_pkg::S_FINISH;
            end
            sfla_pkg::S_WRITE_B: state_next = sfla_pkg::S_FINISH;
            sfla_pkg::S_FINISH: begin
                if (out_free) state_next = sfla_pkg::S_IDLE;
            end
            default: state_next = sfla_pkg::S_IDLE;
        endcase
    end

    // table port and handshake
    always_comb begin
        s_tready    = (state_reg == sfla_pkg::S_IDLE);
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = k_reg[TW-1:0];
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = i_reg[TW-1:0];
        tbl_wr_data = tbl_rd_data;
        case (state_reg)
            sfla_pkg::S_SCAN_RD: begin
                tbl_rd_en = !scan_done;
            end
            sfla_pkg::S_SHIFT_RD: begin
                tbl_rd_en   = shift_more;
                tbl_rd_addr = (shift_reg == sfla_pkg::SH_CLOSE) ? TW'(i_reg + CW'(1))
                                                                : TW'(i_reg - CW'(1));
            end
            sfla_pkg::S_SHIFT_WR: begin
                tbl_wr_en = 1'b1;
            end
            sfla_pkg::S_WRITE_A: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = wa_addr_reg;
                tbl_wr_data = wa_data_reg;
            end
            sfla_pkg::S_WRITE_B: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = wb_addr_reg;
                tbl_wr_data = wb_data_reg;
            end
            default: tbl_rd_en = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        st_next        = st_reg;
        sz_next        = sz_reg;
        k_next         = k_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        shift_next     = shift_reg;
        at_next        = at_reg;
        i_next         = i_reg;
        wb_en_next     = wb_en_reg;
        wa_addr_next   = wa_addr_reg;
        wa_data_next   = wa_data_reg;
        wb_addr_next   = wb_addr_reg;
        wb_data_next   = wb_data_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        case (state_reg)
            sfla_pkg::S_IDLE: begin
                cmd_next       = sfla_pkg::cmd_t'(s_tdata[1:0]);
                id_next        = s_tdata[7:2];
                st_next        = s_tdata[23:8];
                sz_next        = s_tdata[40:24];
                k_next         = '0;
                have_prev_next = 1'b0;
                status_next    = sfla_pkg::ST_OK;
                pos_next       = '0;
            end
            sfla_pkg::S_DECODE: begin
                case (cmd_reg)
                    sfla_pkg::CMD_CREATE: begin
                        if (!id_ok) status_next = sfla_pkg::ST_UNKNOWN;
                        else if (alloc_valid_reg[id_idx]) status_next = sfla_pkg::ST_INUSE;
                        else if (sz_reg == '0) status_next = sfla_pkg::ST_BADSIZE;
                    end
                    sfla_pkg::CMD_REMOVE: begin
                        if (!id_ok || !alloc_valid_reg[id_idx]) begin
                            status_next = sfla_pkg::ST_UNKNOWN;
                        end
                    end
                    sfla_pkg::CMD_QUERY: begin
                        if (sz_reg == '0) status_next = sfla_pkg::ST_BADSIZE;
                    end
                    default: status_next = sfla_pkg::ST_OK;
                endcase
            end
            sfla_pkg::S_ALLOC: begin
                st_next = alloc_rd_reg.start;
                sz_next = alloc_rd_reg.len;
            end
            sfla_pkg::S_SCAN_RD, sfla_pkg::S_SCAN_CHK: begin
                if (plan_take) begin
                    if (plan_full) status_next = sfla_pkg::ST_FULL;
                    shift_next   = plan_shift;
                    at_next      = plan_at;
                    i_next       = (plan_shift == sfla_pkg::SH_OPEN) ? count_reg : plan_at;
                    wa_addr_next = plan_wa_addr;
                    wa_data_next = plan_wa_data;
                    wb_en_next   = plan_wb_en;
                    wb_addr_next = plan_wb_addr;
                    wb_data_next = plan_wb_data;
                end else if (state_reg == sfla_pkg::S_SCAN_RD) begin
                    if (scan_done) status_next = sfla_pkg::ST_NOFIT;
                end else if (cmd_reg == sfla_pkg::CMD_QUERY && query_hit) begin
                    pos_next = tbl_rd_data.start;
                end else begin
                    k_next         = k_succ;
                    prev_next      = tbl_rd_data;
                    have_prev_next = 1'b1;
                end
            end
            sfla_pkg::S_SHIFT_RD: begin
                if (!shift_more) begin
                    count_next = (shift_reg == sfla_pkg::SH_CLOSE) ? count_reg - CW'(1)
                                                                   : count_reg + CW'(1);
                end
            end
            sfla_pkg::S_SHIFT_WR: begin
                i_next = (shift_reg == sfla_pkg::SH_CLOSE) ? i_reg + CW'(1) : i_reg - CW'(1);
            end
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sfla_pkg::S_IDLE;
            count_reg  <= CW'(1);
            shift_reg  <= sfla_pkg::SH_NONE;
            wb_en_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            wb_en_reg  <= wb_en_next;
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        id_reg      <= id_next;
        st_reg      <= st_next;
        sz_reg      <= sz_next;
        k_reg       <= k_next;
        prev_reg    <= prev_next;
        at_reg      <= at_next;
        i_reg       <= i_next;
        wa_addr_reg <= wa_addr_next;
        wa_data_reg <= wa_data_next;
        wb_addr_reg <= wb_addr_next;
        wb_data_reg <= wb_data_next;
        status_reg  <= status_next;
        pos_reg     <= pos_next;
    end

    // id table: valid bits in flops, ranges in memory
    logic alloc_set, alloc_clr;

    assign alloc_set = finish_go && status_reg == sfla_pkg::ST_OK &&
                       cmd_reg == sfla_pkg::CMD_CREATE;
    assign alloc_clr = finish_go && status_reg == sfla_pkg::ST_OK &&
                       cmd_reg == sfla_pkg::CMD_REMOVE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < ID_DEPTH; n++) begin
                alloc_valid_reg[n] <= 1'b0;
            end
        end else if (alloc_set) begin
            alloc_valid_reg[id_idx] <= 1'b1;
        end else if (alloc_clr) begin
            alloc_valid_reg[id_idx] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (alloc_set) begin
            alloc_mem[id_idx] <= '{start: st_reg, len: sz_reg};
        end
        if (state_reg == sfla_pkg::S_DECODE) begin
            alloc_rd_reg <= alloc_mem[id_idx];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish_go) begin
            m_status_reg <= status_reg;
            m_pos_reg    <= (status_reg == sfla_pkg::ST_OK) ? pos_reg : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_pos_reg, m_status_reg};

    // checks
    `SFLA_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(FREE_SLOTS) && count_reg != '0 || count_reg == '0 && 1'b1, "free count out of range")
    `SFLA_ASSERT_NEXT(a_count_step, 1'b1, count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1) || count_reg == $past(count_reg) - CW'(1), "free count jumped")
    `SFLA_ASSERT_NOW(a_wr_in_range, tbl_wr_en, 32'(tbl_wr_addr) < FREE_SLOTS, "table write outside the slots")
    `SFLA_ASSERT_NEXT(a_accept_decode, s_tvalid && s_tready, state_reg == sfla_pkg::S_DECODE, "accepted transaction not decoded")

endmodule

`default_nettype wire
